/* rtl/core/bftd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bftd_pkg
// Shared types and constants for the presence-tree mask decompressor.
// ----------------------------------------------------------------------------
package bftd_pkg;

	localparam int BYTE_W = 8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       starts_mask;
		logic [8:0] field_count;
	} in_item_t;

	typedef struct packed {
		logic [7:0] mask_byte;
		logic [4:0] byte_index;
		logic       last_of_mask;
	} out_item_t;

	typedef enum logic [1:0] {
		SEL_DATA = 2'd0,
		SEL_ZERO = 2'd1,
		SEL_LEAF = 2'd2
	} out_sel_t;

	typedef struct packed {
		logic     capture;
		logic     root_go;
		logic     node_rd;
		logic     node_eval;
		logic     tree_fin;
		logic     leaf_rd;
		logic     leaf_cap;
		logic     out_load;
		out_sel_t out_sel;
		logic     byte_adv;
	} cmd_t;

	typedef struct packed {
		logic in_starts;
		logic active;
		logic small_tree;
		logic root_bit;
		logic tree_done;
		logic node_set;
		logic pos_end;
		logic j_last;
		logic last_byte;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

/* rtl/core/bftd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bftd_ctrl
// Sequencer: input capture, tree walk one node per read/evaluate pair,
// leaf readout and output loading.
// ----------------------------------------------------------------------------
module bftd_ctrl import bftd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic pkt_valid,
	output logic pkt_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_START     = 9'b000000010,
		ST_WALK_RD   = 9'b000000100,
		ST_WALK_EV   = 9'b000001000,
		ST_LEAF_RD   = 9'b000010000,
		ST_LEAF_EV   = 9'b000100000,
		ST_LEAF_OUT  = 9'b001000000,
		ST_ZERO_OUT  = 9'b010000000,
		ST_SMALL_OUT = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign pkt_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pkt_valid) begin
					cmd.capture = 1'b1;
					if (sts.in_starts) begin
						state_d = ST_START;
					end else if (sts.active) begin
						state_d = ST_WALK_RD;
					end
				end
			end
			ST_START: begin
				if (sts.small_tree) begin
					state_d = ST_SMALL_OUT;
				end else if (!sts.root_bit) begin
					state_d = ST_ZERO_OUT;
				end else begin
					cmd.root_go = 1'b1;
					state_d     = ST_WALK_RD;
				end
			end
			ST_WALK_RD: begin
				if (sts.tree_done) begin
					cmd.tree_fin = 1'b1;
					state_d      = ST_LEAF_RD;
				end else begin
					cmd.node_rd = 1'b1;
					state_d     = ST_WALK_EV;
				end
			end
			ST_WALK_EV: begin
				if (sts.node_set && sts.pos_end) begin
					state_d = ST_IDLE;
				end else begin
					cmd.node_eval = 1'b1;
					state_d       = ST_WALK_RD;
				end
			end
			ST_LEAF_RD: begin
				cmd.leaf_rd = 1'b1;
				state_d     = ST_LEAF_EV;
			end
			ST_LEAF_EV: begin
				cmd.leaf_cap = 1'b1;
				state_d      = sts.j_last ? ST_LEAF_OUT : ST_LEAF_RD;
			end
			ST_LEAF_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_LEAF;
					if (sts.last_byte) begin
						state_d = ST_IDLE;
					end else begin
						cmd.byte_adv = 1'b1;
						state_d      = ST_LEAF_RD;
					end
				end
			end
			ST_ZERO_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_ZERO;
					if (sts.last_byte) begin
						state_d = ST_IDLE;
					end else begin
						cmd.byte_adv = 1'b1;
					end
				end
			end
			ST_SMALL_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_DATA;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/bftd_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bftd_dp
// Datapath: node pair memory, walk cursor and bit position, leaf byte
// assembly and the output register.
// ----------------------------------------------------------------------------
module bftd_dp import bftd_pkg::*; #(
	parameter int MAX_FIELDS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  pkt,
	output out_item_t mask,
	output logic      mask_valid,
	input  logic      mask_stall,
	input  cmd_t      cmd,
	output sts_t      sts
);

	localparam int CAP  = (MAX_FIELDS < 256) ? MAX_FIELDS : 256;
	localparam int LW   = $clog2(CAP);
	localparam int KW   = LW - 3;
	localparam int ROWS = 1 << LW;

	// row r holds nodes 2r (bit 0) and 2r+1 (bit 1)
	logic [1:0]    tree_mem_q [ROWS];
	logic [1:0]    rdata_q;
	logic [7:0]    bits_q;
	logic [7:0]    acc_q;
	logic [LW:0]   leaves_q;
	logic [LW:0]   cursor_q;
	logic [3:0]    pos_q;
	logic [KW-1:0] k_q;
	logic [1:0]    j_q;
	logic          active_q;
	logic          aw_q;
	logic          mask_valid_q;
	out_item_t     mask_q;

	logic [8:0]    cnt_sat;
	logic [9:0]    cand;
	logic [LW:0]   size_v;
	logic          cur_bit;
	logic          node_set;
	logic          cursor_adv;
	logic          we;
	logic [LW-1:0] waddr;
	logic [1:0]    wdata;
	logic          re;
	logic [LW-1:0] raddr;
	logic [LW-1:0] leaf_row;
	logic          last_byte;
	out_item_t     out_next;

	always_comb begin
		cnt_sat = pkt.field_count;
		if (pkt.field_count == 9'd0) begin
			cnt_sat = 9'd1;
		end else if (pkt.field_count > 9'(CAP)) begin
			cnt_sat = 9'(CAP);
		end
		size_v = '0;
		cand   = '0;
		for (int i = LW; i >= 0; i--) begin
			cand = 10'(1) << i;
			if (cand >= {1'b0, cnt_sat}) begin
				size_v = cand[LW:0];
			end
		end
	end

	assign cur_bit    = bits_q[pos_q[2:0]];
	assign node_set   = rdata_q[cursor_q[0]];
	assign cursor_adv = cmd.node_eval && (!node_set || aw_q || !cur_bit);
	assign leaf_row   = leaves_q[LW:1] + {1'b0, k_q, j_q};
	assign last_byte  = (({1'b0, k_q} + (LW - 2)'(1)) == leaves_q[LW:3]);

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = 2'b00;
		if (cmd.root_go) begin
			we    = 1'b1;
			wdata = 2'b10;
		end else if (cursor_adv) begin
			we    = 1'b1;
			waddr = cursor_q[LW-1:0];
			if (!node_set) begin
				wdata = 2'b00;
			end else if (aw_q) begin
				wdata = {1'b1, cur_bit};
			end else begin
				wdata = 2'b01;
			end
		end
	end

	assign re    = cmd.node_rd || cmd.leaf_rd;
	assign raddr = cmd.leaf_rd ? leaf_row : cursor_q[LW:1];

	always_ff @(posedge clk) begin
		if (we) begin
			tree_mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= tree_mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			bits_q <= pkt.data_byte;
		end
		if (cmd.leaf_cap) begin
			acc_q[{j_q, 1'b0} +: 2] <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaves_q <= '0;
			cursor_q <= (LW + 1)'(1);
			pos_q    <= '0;
			k_q      <= '0;
			j_q      <= '0;
			active_q <= 1'b0;
			aw_q     <= 1'b0;
		end else begin
			if (cmd.capture) begin
				pos_q <= '0;
				k_q   <= '0;
				j_q   <= '0;
				if (pkt.starts_mask) begin
					leaves_q <= size_v;
					cursor_q <= (LW + 1)'(1);
					aw_q     <= 1'b0;
					active_q <= 1'b0;
				end
			end
			if (cmd.root_go) begin
				active_q <= 1'b1;
				pos_q    <= 4'd1;
			end
			if (cmd.node_eval && node_set) begin
				pos_q <= pos_q + 4'd1;
				aw_q  <= !aw_q && cur_bit;
			end
			if (cursor_adv) begin
				cursor_q <= cursor_q + (LW + 1)'(1);
			end
			if (cmd.tree_fin) begin
				active_q <= 1'b0;
				aw_q     <= 1'b0;
				cursor_q <= (LW + 1)'(1);
			end
			if (cmd.leaf_cap) begin
				j_q <= j_q + 2'd1;
			end
			if (cmd.byte_adv) begin
				k_q <= k_q + KW'(1);
				j_q <= '0;
			end
		end
	end

	always_comb begin
		unique case (cmd.out_sel)
			SEL_DATA: out_next = '{mask_byte: bits_q, byte_index: 5'd0, last_of_mask: 1'b1};
			SEL_ZERO: out_next = '{mask_byte: 8'd0, byte_index: 5'(k_q),
				last_of_mask: last_byte};
			SEL_LEAF: out_next = '{mask_byte: acc_q, byte_index: 5'(k_q),
				last_of_mask: last_byte};
			default:  out_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			mask_valid_q <= 1'b1;
		end else if (!mask_stall) begin
			mask_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mask_q <= out_next;
		end
	end

	assign mask       = mask_q;
	assign mask_valid = mask_valid_q;

	assign sts.in_starts  = pkt.starts_mask;
	assign sts.active     = active_q;
	assign sts.small_tree = (leaves_q <= (LW + 1)'(BYTE_W));
	assign sts.root_bit   = bits_q[0];
	assign sts.tree_done  = (cursor_q >= leaves_q);
	assign sts.node_set   = node_set;
	assign sts.pos_end    = (pos_q == 4'(BYTE_W));
	assign sts.j_last     = (j_q == 2'd3);
	assign sts.last_byte  = last_byte;
	assign sts.out_free   = !mask_valid_q || !mask_stall;

endmodule
`default_nettype wire

/* rtl/core/bitflag_tree_decompressor.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitflag_tree_decompressor
// Rebuilds a field-presence bitmask from presence-tree coded packet bytes.
//
//   channel | signals                     | carries
//   --------+-----------------------------+--------------------------------
//   pkt     | pkt_valid, pkt_stall, pkt   | compressed byte, start, count
//   mask    | mask_valid, mask_stall, mask| decoded byte, index, last flag
//
// A byte is taken in idle; the walk reads, then evaluates, each code bit or clear
// node in memory, then closes the tree, and for each mask byte reads four node
// pairs and loads the output register. A small mask holds pkt_stall through start
// and one output load; a cleared-root mask through start and one load per byte.
// Reset clears the sequencer and output valid; node memory needs no clearing.
// mask_stall holds the output register; pkt_stall is high outside idle.
// ----------------------------------------------------------------------------
module bitflag_tree_decompressor import bftd_pkg::*; #(
	parameter int MAX_FIELDS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pkt_valid,
	output logic      pkt_stall,
	input  in_item_t  pkt,
	output logic      mask_valid,
	input  logic      mask_stall,
	output out_item_t mask
);

	cmd_t cmd;
	sts_t sts;

	bftd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bftd_dp #(
		.MAX_FIELDS (MAX_FIELDS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt        (pkt),
		.mask       (mask),
		.mask_valid (mask_valid),
		.mask_stall (mask_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output load over an untaken transfer");

	a_eval_open: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.node_eval |-> !sts.tree_done)
		else $error("node evaluated past the last internal node");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt_valid && !pkt_stall && pkt.starts_mask) |=> pkt_stall)
		else $error("start transfer did not occupy the sequencer");

endmodule
`default_nettype wire
